### design/lbtf_pkg.sv
// ----------------------------------------------------------------------------
// lbtf_pkg: shared definitions for the LED breathing fader
// Field widths, register reset values, register indexes and the
// control and configuration structs used between the fader modules.
// ----------------------------------------------------------------------------
package lbtf_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PERIOD_W      = 16;
  localparam int INTENS_W      = 16;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 4;

  localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 16'd1000;
  localparam logic [PERIOD_W-1:0] NEXT_PERIOD_RST  = 16'd1000;
  localparam logic [INTENS_W-1:0] INTENS_LOW_RST   = 16'd0;
  localparam logic [INTENS_W-1:0] INTENS_HIGH_RST  = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_START_PERIOD = 2'd0,
    REG_NEXT_PERIOD  = 2'd1,
    REG_INTENS_LOW   = 2'd2,
    REG_INTENS_HIGH  = 2'd3
  } lbtf_reg_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] start_period;
    logic [PERIOD_W-1:0] next_period;
    logic [INTENS_W-1:0] intens_low;
    logic [INTENS_W-1:0] intens_high;
  } lbtf_cfg_t;

  // Control of a bit-serial unit: load its operands, or advance one bit.
  typedef struct packed {
    logic load;
    logic shift;
  } lbtf_ser_ctrl_t;

endpackage

### design/lbtf_apb_regs.sv
// ----------------------------------------------------------------------------
// lbtf_apb_regs: configuration register file
// Four 16-bit registers on an APB-style port, word addressed.
// ----------------------------------------------------------------------------
module lbtf_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lbtf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lbtf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lbtf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output lbtf_pkg::lbtf_cfg_t              cfg_o,
  output logic                             start_wr_o
);

  lbtf_pkg::lbtf_cfg_t cfg_q;
  lbtf_pkg::lbtf_reg_e idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = lbtf_pkg::lbtf_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_period <= lbtf_pkg::START_PERIOD_RST;
      cfg_q.next_period  <= lbtf_pkg::NEXT_PERIOD_RST;
      cfg_q.intens_low   <= lbtf_pkg::INTENS_LOW_RST;
      cfg_q.intens_high  <= lbtf_pkg::INTENS_HIGH_RST;
    end else if (wr_en) begin
      case (idx)
        lbtf_pkg::REG_START_PERIOD: cfg_q.start_period <= pwdata[15:0];
        lbtf_pkg::REG_NEXT_PERIOD:  cfg_q.next_period  <= pwdata[15:0];
        lbtf_pkg::REG_INTENS_LOW:   cfg_q.intens_low   <= pwdata[15:0];
        lbtf_pkg::REG_INTENS_HIGH:  cfg_q.intens_high  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lbtf_pkg::REG_START_PERIOD: prdata = {16'd0, cfg_q.start_period};
      lbtf_pkg::REG_NEXT_PERIOD:  prdata = {16'd0, cfg_q.next_period};
      lbtf_pkg::REG_INTENS_LOW:   prdata = {16'd0, cfg_q.intens_low};
      lbtf_pkg::REG_INTENS_HIGH:  prdata = {16'd0, cfg_q.intens_high};
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o      = cfg_q;
  assign start_wr_o = wr_en && (idx == lbtf_pkg::REG_START_PERIOD);

endmodule

### design/lbtf_elapsed.sv
// ----------------------------------------------------------------------------
// lbtf_elapsed: bit-serial elapsed time
// Subtracts the stored tick from the new one LSB first, compares the
// difference against the ramp period, and swaps the new tick into storage.
// ----------------------------------------------------------------------------
module lbtf_elapsed #(
  parameter int TIME_BITS = lbtf_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lbtf_pkg::lbtf_ser_ctrl_t      ctrl_i,
  input  logic [TIME_BITS-1:0]          now_i,
  input  logic [lbtf_pkg::PERIOD_W-1:0] per_i,
  output logic [lbtf_pkg::PERIOD_W-1:0] elapsed_lo_o,
  output logic                          ge_o,
  output logic                          nz_o
);

  logic [TIME_BITS-1:0]          now_sh_q;  // new tick in, elapsed time out
  logic [TIME_BITS-1:0]          last_q;    // stored tick
  logic [lbtf_pkg::PERIOD_W-1:0] per_sh_q;
  logic                          borrow_q;
  logic                          ge_q;
  logic                          nz_q;
  logic                          n_bit;
  logic                          l_bit;
  logic                          e_bit;

  assign n_bit = now_sh_q[0];
  assign l_bit = last_q[0];
  assign e_bit = n_bit ^ l_bit ^ borrow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (ctrl_i.shift) begin
      last_q <= {n_bit, last_q[TIME_BITS-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      now_sh_q <= now_i;
      per_sh_q <= per_i;
      borrow_q <= 1'b0;
      ge_q     <= 1'b1;
      nz_q     <= 1'b0;
    end else if (ctrl_i.shift) begin
      now_sh_q <= {e_bit, now_sh_q[TIME_BITS-1:1]};
      per_sh_q <= {1'b0, per_sh_q[lbtf_pkg::PERIOD_W-1:1]};
      borrow_q <= (!n_bit && l_bit) || (!(n_bit ^ l_bit) && borrow_q);
      // LSB-first compare: the highest differing bit decides
      if (e_bit != per_sh_q[0]) begin
        ge_q <= e_bit;
      end
      nz_q <= nz_q || l_bit;
    end
  end

  assign elapsed_lo_o = now_sh_q[lbtf_pkg::PERIOD_W-1:0];
  assign ge_o         = ge_q;
  assign nz_o         = nz_q;

endmodule

### design/lbtf_step_div.sv
// ----------------------------------------------------------------------------
// lbtf_step_div: bit-serial step divider
// Restoring division of 2 * elapsed * 2^FRAC_BITS by the period, one
// quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module lbtf_step_div #(
  parameter int FRAC_BITS = lbtf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  lbtf_pkg::lbtf_ser_ctrl_t      ctrl_i,
  input  logic [lbtf_pkg::PERIOD_W-1:0] elapsed_i,
  input  logic                          nz_i,
  input  logic [lbtf_pkg::PERIOD_W-1:0] per_i,
  output logic [FRAC_BITS:0]            quot_o
);

  logic [lbtf_pkg::PERIOD_W-1:0] rem_q;
  logic [FRAC_BITS:0]            quot_q;
  logic [lbtf_pkg::PERIOD_W:0]   rem2;
  logic [lbtf_pkg::PERIOD_W:0]   diff;
  logic                          fits;

  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, per_i};
  assign fits = rem2 >= {1'b0, per_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q  <= nz_i ? elapsed_i : '0;
      quot_q <= '0;
    end else if (ctrl_i.shift) begin
      rem_q  <= fits ? diff[lbtf_pkg::PERIOD_W-1:0] : rem2[lbtf_pkg::PERIOD_W-1:0];
      quot_q <= {quot_q[FRAC_BITS-1:0], fits};
    end
  end

  assign quot_o = quot_q;

endmodule

### design/lbtf_intens_mul.sv
// ----------------------------------------------------------------------------
// lbtf_intens_mul: bit-serial intensity interpolation
// Shift-add multiply of the span magnitude by the level, LSB first, then
// drop the fraction, restore the sign and add the low bound.
// ----------------------------------------------------------------------------
module lbtf_intens_mul #(
  parameter int FRAC_BITS = lbtf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  lbtf_pkg::lbtf_ser_ctrl_t      ctrl_i,
  input  logic [FRAC_BITS:0]            level_i,
  input  logic [lbtf_pkg::INTENS_W-1:0] low_i,
  input  logic [lbtf_pkg::INTENS_W-1:0] high_i,
  output logic [lbtf_pkg::INTENS_W-1:0] intensity_o
);

  localparam int LVL_W = FRAC_BITS + 1;
  localparam int IW    = lbtf_pkg::INTENS_W;

  logic [IW:0]         span;
  logic                neg;
  logic [IW-1:0]       mag;
  logic [IW+LVL_W-1:0] acc_q;   // {partial sum, level bits still to use}
  logic [IW:0]         sum;
  logic [IW:0]         part;
  logic [IW-1:0]       part_s;

  assign span = {1'b0, high_i} - {1'b0, low_i};
  assign neg  = span[IW];
  assign mag  = neg ? (~span[IW-1:0] + 1'b1) : span[IW-1:0];
  assign sum  = {1'b0, acc_q[IW+LVL_W-1:LVL_W]} + (acc_q[0] ? {1'b0, mag} : '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= {{IW{1'b0}}, level_i};
    end else if (ctrl_i.shift) begin
      acc_q <= {sum, acc_q[LVL_W-1:1]};
    end
  end

  assign part        = acc_q[IW+LVL_W-1:FRAC_BITS];
  assign part_s      = neg ? (~part[IW-1:0] + 1'b1) : part[IW-1:0];
  assign intensity_o = low_i + part_s;

endmodule

### design/led_breathe_triangle_fader.sv
// ----------------------------------------------------------------------------
// led_breathe_triangle_fader: triangle-wave LED breathing generator
// Turns millisecond ticks into a rising and falling brightness level and
// an intensity interpolated between two programmable bounds.
// ----------------------------------------------------------------------------
// Each input beat carries a tick count; each one yields exactly one output
// beat with the intensity, the Q1.FRAC_BITS level and the direction. Work
// on a beat is bit serial and runs in order: acceptance of the tick, serial
// subtraction for the elapsed time, the restoring step divider, the level
// update, the shift-add intensity multiplier, and the load of the output
// register; no new tick is accepted before that load. The finished beat
// waits in that register, so the next tick is taken while the sink stalls.
// The user must write registers on the APB port only while no beat is in
// flight; the block itself does not enforce it. A write of the start period
// also reloads the running ramp period.
module led_breathe_triangle_fader #(
  parameter int TIME_BITS = lbtf_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = lbtf_pkg::FRAC_BITS_DEF,
  localparam int IN_W     = ((TIME_BITS + 7) / 8) * 8,
  localparam int OUT_FW   = lbtf_pkg::INTENS_W + FRAC_BITS + 2,
  localparam int OUT_W    = ((OUT_FW + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side, tdata from bit 0: now_ms[TIME_BITS-1:0], zero pad
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,
  // master side, tdata from bit 0: intensity[15:0], level_out[FRAC_BITS:0],
  // falling, zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lbtf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [lbtf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [lbtf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int LVL_W   = FRAC_BITS + 1;
  localparam int NL_W    = FRAC_BITS + 3;
  localparam int CNT_MAX = (TIME_BITS > LVL_W) ? TIME_BITS : LVL_W;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int PW      = lbtf_pkg::PERIOD_W;

  localparam logic [LVL_W-1:0] ONE_LVL = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [NL_W-1:0]  ONE_NL  = {2'b00, ONE_LVL};
  localparam logic [NL_W-1:0]  TWO_NL  = {1'b0, ONE_LVL, 1'b0};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUB  = 6'b000010,
    S_DIV  = 6'b000100,
    S_UPD  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } lbtf_state_e;

  lbtf_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  lbtf_pkg::lbtf_cfg_t      cfg;
  logic                     start_wr;
  lbtf_pkg::lbtf_ser_ctrl_t sub_ctrl, div_ctrl, mul_ctrl;

  logic [LVL_W-1:0] level_q;
  logic             down_q;
  logic [PW-1:0]    period_q;
  logic [PW-1:0]    per_eff;

  logic [PW-1:0]             elapsed_lo;
  logic                      ge;
  logic                      nz;
  logic [LVL_W-1:0]          quot;
  logic [lbtf_pkg::INTENS_W-1:0] intensity;

  logic [LVL_W-1:0] step;
  logic [NL_W-1:0]  nl_sum;
  logic [NL_W-1:0]  nl_fix;
  logic             down_upd;
  logic             reload_per;
  logic [LVL_W-1:0] level_upd;

  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;
  logic             in_beat;
  logic             out_load;

  lbtf_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_o      (cfg),
    .start_wr_o (start_wr)
  );

  // A zero period behaves as a period of one millisecond.
  assign per_eff = (period_q == '0) ? PW'(1) : period_q;

  lbtf_elapsed #(.TIME_BITS(TIME_BITS)) u_elapsed (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (sub_ctrl),
    .now_i        (s_axis_tdata[TIME_BITS-1:0]),
    .per_i        (per_eff),
    .elapsed_lo_o (elapsed_lo),
    .ge_o         (ge),
    .nz_o         (nz)
  );

  lbtf_step_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i     (clk_i),
    .ctrl_i    (div_ctrl),
    .elapsed_i (elapsed_lo),
    .nz_i      (nz),
    .per_i     (per_eff),
    .quot_o    (quot)
  );

  lbtf_intens_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i       (clk_i),
    .ctrl_i      (mul_ctrl),
    .level_i     (level_upd),
    .low_i       (cfg.intens_low),
    .high_i      (cfg.intens_high),
    .intensity_o (intensity)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // Sequence the serial units.
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    sub_ctrl       = '0;
    div_ctrl       = '0;
    mul_ctrl       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          sub_ctrl.load = 1'b1;
          cnt_d         = CNT_W'(TIME_BITS - 1);
          state_d       = S_SUB;
        end
      end
      S_SUB: begin
        sub_ctrl.shift = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(LVL_W);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // first cycle loads the remainder, the rest yield one bit each
        if (cnt_q == CNT_W'(LVL_W)) begin
          div_ctrl.load = 1'b1;
        end else begin
          div_ctrl.shift = 1'b1;
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        mul_ctrl.load = 1'b1;
        cnt_d         = CNT_W'(LVL_W - 1);
        state_d       = S_MUL;
      end
      S_MUL: begin
        mul_ctrl.shift = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Saturate the step at full scale; a whole period or more is full scale.
  always_comb begin
    if (ge && nz) begin
      step = ONE_LVL;
    end else if (quot[FRAC_BITS] && (|quot[FRAC_BITS-1:0])) begin
      step = ONE_LVL;
    end else begin
      step = quot;
    end
  end

  // Move the level and reflect it at full and at zero.
  always_comb begin
    nl_sum     = down_q ? ({2'b00, level_q} - {2'b00, step})
                        : ({2'b00, level_q} + {2'b00, step});
    nl_fix     = nl_sum;
    down_upd   = down_q;
    reload_per = 1'b0;
    if (!nl_sum[NL_W-1] && (nl_sum >= ONE_NL)) begin
      nl_fix     = TWO_NL - nl_sum;
      down_upd   = 1'b1;
      reload_per = 1'b1;
    end else if (nl_sum[NL_W-1]) begin
      nl_fix     = '0 - nl_sum;
      down_upd   = 1'b0;
      reload_per = 1'b1;
    end
    level_upd = nl_fix[LVL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      level_q  <= '0;
      down_q   <= 1'b0;
      period_q <= lbtf_pkg::START_PERIOD_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == S_UPD) begin
        level_q <= level_upd;
        down_q  <= down_upd;
        if (reload_per) begin
          period_q <= cfg.next_period;
        end
      end else if (start_wr) begin
        period_q <= pwdata[PW-1:0];
      end
    end
  end

  // Output register: hold the beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= OUT_W'({down_q, level_q, intensity});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // An accepted tick starts the serial subtraction at once.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == S_SUB))
    else $error("accepted tick did not start the subtraction");

  // The level never leaves the range zero to full scale.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= ONE_LVL)
    else $error("level above full scale");

  // A new output beat appears only after the output state.
  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("output beat raised outside the output state");

  // No new tick is taken while the divider or multiplier is busy.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) || (state_q == S_MUL)) |-> !s_axis_tready)
    else $error("tick accepted while busy");

endmodule

### bench/led_breathe_triangle_fader_tb.sv
// ----------------------------------------------------------------------------
// led_breathe_triangle_fader_tb: self-checking bench for the breathing fader
// Streams millisecond ticks into the fader under several register settings,
// mirrors the triangle-wave level, direction and intensity in a small
// tracking class, and checks every output beat and every register readback.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_breathe_triangle_fader_tb;

  localparam int  IN_W          = 32;
  localparam int  OUT_W         = 40;
  localparam int  LATENCY       = 70;       // drain allowance for a beat still in the fader
  localparam int  CYCLE_LIMIT   = 800_000;
  localparam int  PHASE_TICKS   = 186;
  localparam int  RANDOM_PHASES = 6;
  localparam int  LONG_HOLD     = 600;
  localparam longint LEVEL_ONE  = 64'd65536;

  // One expected output beat.
  typedef struct packed {
    logic [15:0] intensity;
    logic [16:0] level;
    logic        falling;
  } fade_beat_t;

  // Shadow copy of the fader: registers, ramp state and the beats still owed.
  class fader_mirror;
    logic [15:0] start_period, next_period, intens_low, intens_high;
    logic [16:0] level;
    logic        falling;
    logic [15:0] period_now;
    logic [31:0] last_ms;
    fade_beat_t  owed_beats[$];
    int          fail_count, reversals, beats_seen;

    function new();
      start_period = lbtf_pkg::START_PERIOD_RST;
      next_period  = lbtf_pkg::NEXT_PERIOD_RST;
      intens_low   = lbtf_pkg::INTENS_LOW_RST;
      intens_high  = lbtf_pkg::INTENS_HIGH_RST;
      level        = '0;
      falling      = 1'b0;
      period_now   = lbtf_pkg::START_PERIOD_RST;
      last_ms      = '0;
      fail_count   = 0;
      reversals    = 0;
      beats_seen   = 0;
    endfunction

    function void set_reg(lbtf_pkg::lbtf_reg_e idx, logic [15:0] val);
      case (idx)
        lbtf_pkg::REG_START_PERIOD: begin
          start_period = val;
          period_now   = val;
        end
        lbtf_pkg::REG_NEXT_PERIOD: next_period = val;
        lbtf_pkg::REG_INTENS_LOW:  intens_low  = val;
        lbtf_pkg::REG_INTENS_HIGH: intens_high = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] reg_value(lbtf_pkg::lbtf_reg_e idx);
      case (idx)
        lbtf_pkg::REG_START_PERIOD: return start_period;
        lbtf_pkg::REG_NEXT_PERIOD:  return next_period;
        lbtf_pkg::REG_INTENS_LOW:   return intens_low;
        default:                    return intens_high;
      endcase
    endfunction

    // Advance the ramp by one tick and queue the beat it must produce.
    function void note_tick(logic [31:0] now_ms);
      logic [31:0] diff;
      longint      elapsed, per, step, lv, lo, hi, prod, part;
      fade_beat_t  beat;
      diff    = now_ms - last_ms;
      elapsed = (last_ms != 32'd0) ? longint'(diff) : 64'sd0;
      per     = longint'(period_now);
      if (per == 0) per = 1;
      if (elapsed >= per) begin
        step = LEVEL_ONE;
      end else begin
        step = (2 * elapsed * LEVEL_ONE) / per;
        if (step > LEVEL_ONE) step = LEVEL_ONE;
      end
      lv = longint'(level);
      lv = falling ? lv - step : lv + step;
      // Reflect off full first, then off zero, regardless of direction.
      if (lv >= LEVEL_ONE) begin
        lv         = 2 * LEVEL_ONE - lv;
        falling    = 1'b1;
        period_now = next_period;
        reversals++;
      end else if (lv < 0) begin
        lv         = -lv;
        falling    = 1'b0;
        period_now = next_period;
        reversals++;
      end
      level   = 17'(lv);
      last_ms = now_ms;
      lo   = longint'(intens_low);
      hi   = longint'(intens_high);
      prod = (hi - lo) * lv;
      part = (prod >= 0) ? (prod >>> 16) : -((-prod) >>> 16);
      beat.intensity = 16'(lo + part);
      beat.level     = level;
      beat.falling   = falling;
      owed_beats.push_back(beat);
    endfunction

    // Compare an output beat field by field against the oldest owed beat.
    function void check_beat(logic [OUT_W-1:0] data);
      fade_beat_t want, got;
      got.intensity = data[15:0];
      got.level     = data[32:16];
      got.falling   = data[33];
      beats_seen++;
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected beat intensity=%h level=%h falling=%b",
                 $time, got.intensity, got.level, got.falling);
        fail_count++;
        return;
      end
      want = owed_beats.pop_front();
      if (got.intensity !== want.intensity) begin
        $display("%0t: intensity expected %h actual %h", $time, want.intensity, got.intensity);
        fail_count++;
      end
      if (got.level !== want.level) begin
        $display("%0t: level expected %h actual %h", $time, want.level, got.level);
        fail_count++;
      end
      if (got.falling !== want.falling) begin
        $display("%0t: falling expected %b actual %b", $time, want.falling, got.falling);
        fail_count++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [IN_W-1:0]                 s_axis_tdata;   // now_ms[31:0]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [OUT_W-1:0]                m_axis_tdata;   // intensity[15:0], level_out[16:0], falling, pad
  logic                            psel, penable, pwrite;
  logic [lbtf_pkg::CFG_ADDR_W-1:0] paddr;
  logic [lbtf_pkg::CFG_DATA_W-1:0] pwdata;
  logic [lbtf_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  fader_mirror mirror;
  int          cycle_count  = 0;
  int          ticks_sent   = 0;
  int          settings_run = 0;
  int          hold_request = 0;   // long sink hold asked by the stimulus thread
  int          longest_hold = 0;
  int          stall_left   = 0;
  bit          calm         = 1'b0; // no idling on either side while set
  logic [31:0] clock_ms     = '0;

  led_breathe_triangle_fader dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog: the slowest correct run is far below this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats still owed", $time, mirror.owed_beats.size());
      $display("led_breathe_triangle_fader verification failed");
      $finish;
    end
  end

  // Observe both streams at the rising edge. Note the input beat before
  // checking the output beat so the order of the two never matters.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) mirror.note_tick(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) mirror.check_beat(m_axis_tdata);
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // Sink: random backpressure, plus one long hold on request, counted here.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        longest_hold = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one tick after a random gap and hold it until the fader takes it.
  task automatic send_tick(logic [31:0] now_ms);
    int gap;
    gap = calm ? 0 : idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now_ms;
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  task automatic apb_access(lbtf_pkg::lbtf_reg_e idx, logic wr, logic [15:0] val);
    logic [15:0] junk;
    junk = 16'($urandom);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, val};   // upper half is don't-care for 16-bit registers
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      mirror.set_reg(idx, val);
    end else if (prdata !== {16'd0, mirror.reg_value(idx)}) begin
      $display("%0t: register %s expected %h actual %h", $time, idx.name(),
               {16'd0, mirror.reg_value(idx)}, prdata);
      mirror.fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain every owed beat, let the fader fall idle, then program and read back.
  task automatic apply_settings(logic [15:0] sp, logic [15:0] np,
                                logic [15:0] lo, logic [15:0] hi);
    lbtf_pkg::lbtf_reg_e idx;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mirror.owed_beats.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    apb_access(lbtf_pkg::REG_START_PERIOD, 1'b1, sp);
    apb_access(lbtf_pkg::REG_NEXT_PERIOD,  1'b1, np);
    apb_access(lbtf_pkg::REG_INTENS_LOW,   1'b1, lo);
    apb_access(lbtf_pkg::REG_INTENS_HIGH,  1'b1, hi);
    idx = idx.first();
    do begin
      apb_access(idx, 1'b0, '0);
      idx = idx.next();
    end while (idx != idx.first());
    settings_run++;
  endtask

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom_range(0, 1));
    if (r < 70) return 16'($urandom_range(2, 300));
    if (r < 90) return 16'($urandom_range(301, 5000));
    return (r < 95) ? 16'hFFFF : 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_bound();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Mostly a well-formed ramp: ticks advance by up to half the period, at
  // times up to two periods, so the level climbs, falls and reflects often.
  // The rest repeats a tick, sends a zero tick, jumps anywhere or parks below the wrap.
  task automatic run_ticks(int count, logic [15:0] per_hint);
    int r, span;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        span     = (r < 65) ? (per_hint / 2 + 1) : (2 * per_hint + 1);
        clock_ms = clock_ms + $urandom_range(0, span);
      end else if (r < 86) begin
        clock_ms = clock_ms;
      end else if (r < 90) begin
        clock_ms = '0;
      end else if (r < 95) begin
        clock_ms = $urandom;
      end else begin
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
      end
      send_tick(clock_ms);
    end
  endtask

  initial begin
    logic [15:0] sp, np;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mirror        = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values first, then a ramp at the default 1000 ms period:
    // ticks after a zero tick give no elapsed time, a quarter-period step
    // lands exactly on full, a repeated tick rests there while falling,
    // a full step hits zero, then reflection off zero, wrap and huge jumps.
    apply_settings(lbtf_pkg::START_PERIOD_RST, lbtf_pkg::NEXT_PERIOD_RST,
                   lbtf_pkg::INTENS_LOW_RST, lbtf_pkg::INTENS_HIGH_RST);
    send_tick(32'd0);
    send_tick(32'd100);
    send_tick(32'd350);
    send_tick(32'd600);
    send_tick(32'd600);
    send_tick(32'd1100);
    send_tick(32'd1101);
    send_tick(32'd0);
    send_tick(32'd5);
    send_tick(32'hFFFF_FF00);
    send_tick(32'h0000_0010);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h7FFF_FFFF);
    send_tick(32'h8000_0000);

    // Zero periods act as one; inverted bounds interpolate downward.
    apply_settings(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_tick(32'h8000_0001);
    send_tick(32'h8000_0001);
    send_tick(32'h8000_0003);

    // Longest period: tiny steps, and a step that clamps inside the divide.
    apply_settings(16'hFFFF, 16'hFFFF, 16'h1234, 16'hFEDC);
    clock_ms = 32'h8000_0003;
    send_tick(clock_ms + 32'd1);
    send_tick(clock_ms + 32'd32768);
    send_tick(clock_ms + 32'd98302);
    send_tick(clock_ms + 32'd163837);
    clock_ms = clock_ms + 32'd163837;

    // Random settings, each with a long run of ticks. The third phase
    // holds the sink off long enough for the fader to fill and stall.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sp = (p == 0) ? 16'd1 : pick_period();
      np = (p == 0) ? 16'd2 : pick_period();
      apply_settings(sp, np, pick_bound(), pick_bound());
      calm = (p == 4);
      if (p == 2) hold_request = LONG_HOLD;
      run_ticks(PHASE_TICKS, (np > sp) ? np : sp);
    end
    calm = 1'b0;

    // Drop valid, drain, and allow the fader's latency for anything stray.
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mirror.owed_beats.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("covered %0d ticks and %0d beats over %0d register settings, %0d reversals",
             ticks_sent, mirror.beats_seen, settings_run, mirror.reversals);
    $display("sink held off for %0d cycles once; %0d mismatches",
             longest_hold, mirror.fail_count);
    if (mirror.fail_count == 0) begin
      $display("led_breathe_triangle_fader verification clean");
    end else begin
      $display("led_breathe_triangle_fader verification failed");
    end
    $finish;
  end

endmodule
